### design/ipce_pkg.sv
// Shared types and constants for the IPC endpoint rendezvous table.
// Used by the core, ipce_alloc, ipce_exec and the testbench; depends on nothing.
package ipce_pkg;

  localparam int NUM_ENDPOINTS = 64;
  localparam int MSG_WIDTH     = 64;
  localparam int EP_W          = 6;
  localparam int TASK_W        = 6;
  localparam int PORT_MSG_W    = 64;
  localparam int EP_AW         = $clog2(NUM_ENDPOINTS);
  localparam int GRP_SIZE      = 8;
  localparam int GRP_AW        = $clog2(GRP_SIZE);
  localparam int NUM_GRPS      = NUM_ENDPOINTS / GRP_SIZE;
  localparam int SEL_AW        = EP_AW - GRP_AW;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_SEND    = 2'd2,
    OP_RECEIVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FAIL  = 2'd1,
    ST_BLOCK = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // One endpoint entry as stored in the table memory.
  typedef struct packed {
    logic                 pend;
    logic                 snd_wait;
    logic [TASK_W-1:0]    snd_id;
    logic                 rcv_wait;
    logic [TASK_W-1:0]    rcv_id;
    logic [MSG_WIDTH-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Update of the active marks.
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [EP_AW-1:0] idx;
  } act_upd_t;

  // Everything one request produces in its execute cycle.
  typedef struct packed {
    logic              wr_en;
    logic [EP_AW-1:0]  wr_addr;
    entry_t            wr_data;
    act_upd_t          act;
    status_t           status;
    logic [EP_W-1:0]   created;
    logic [MSG_WIDTH-1:0] received;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
  } exec_out_t;

endpackage

### design/ipc_endpoint_rendezvous_table_core.sv
// Top level of the IPC endpoint rendezvous table: request capture, sequencer,
// result register. Depends on ipce_pkg, ipce_ram, ipce_alloc and ipce_exec.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------------------
//  request   | start & !busy        | opcode, endpoint, caller_task, message
//  result    | done (one cycle)     | status, created_endpoint, received_message,
//            |                      | wake_valid, wake_task
//
// Each request is one read-modify-write: the accept edge issues the table memory read,
// the next edge writes the entry back and registers the result. busy holds off a new
// request until that single read-modify-write on the table memory is done.
// done pulses in the cycle after the writeback; a new request can be taken in
// that same cycle. The receiver cannot hold done off, so nothing stalls here.
// Reset clears all active marks at once; no clearing pass. Create zeroes the
// claimed entry, so table contents need no reset.
module ipc_endpoint_rendezvous_table_core
  import ipce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            opcode,
  input  logic [EP_W-1:0]       endpoint,
  input  logic [TASK_W-1:0]     caller_task,
  input  logic [PORT_MSG_W-1:0] message,
  output logic                  done,
  output logic [1:0]            status,
  output logic [EP_W-1:0]       created_endpoint,
  output logic [PORT_MSG_W-1:0] received_message,
  output logic                  wake_valid,
  output logic [TASK_W-1:0]     wake_task
);

  state_t               state;
  state_t               state_next;
  logic                 accept;
  logic                 exec_en;
  op_t                  req_op;
  logic [EP_W-1:0]      req_ep;
  logic [TASK_W-1:0]    req_caller;
  logic [MSG_WIDTH-1:0] req_msg;
  logic [ENTRY_W-1:0]   rd_word;
  entry_t               rd_entry;
  logic                 ep_active;
  logic                 free_found;
  logic [EP_AW-1:0]     free_idx;
  exec_out_t            res;
  act_upd_t             act_upd;

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    exec_en = 1'b0;
    case (state)
      S_IDLE:  busy = 1'b0;
      S_EXEC: begin
        busy    = 1'b1;
        exec_en = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec_en;
    end
  end

  // Hold the request beat for the execute cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op     <= op_t'(opcode);
      req_ep     <= endpoint;
      req_caller <= caller_task;
      req_msg    <= message[MSG_WIDTH-1:0];
    end
  end

  ipce_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_ENDPOINTS)
  ) u_table (
    .clk   (clk),
    .we    (exec_en && res.wr_en),
    .waddr (res.wr_addr),
    .wdata (res.wr_data),
    .re    (accept),
    .raddr (endpoint[EP_AW-1:0]),
    .rdata (rd_word)
  );

  assign rd_entry = entry_t'(rd_word);

  always_comb begin
    act_upd     = res.act;
    act_upd.set = exec_en && res.act.set;
    act_upd.clr = exec_en && res.act.clr;
  end

  ipce_alloc u_alloc (
    .clk        (clk),
    .rst        (rst),
    .upd        (act_upd),
    .query_idx  (req_ep[EP_AW-1:0]),
    .query_act  (ep_active),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  ipce_exec u_exec (
    .op         (req_op),
    .ep         (req_ep),
    .caller     (req_caller),
    .msg        (req_msg),
    .entry      (rd_entry),
    .ep_active  (ep_active),
    .free_found (free_found),
    .free_idx   (free_idx),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (exec_en) begin
      status           <= res.status;
      created_endpoint <= res.created;
      received_message <= PORT_MSG_W'(res.received);
      wake_valid       <= res.wake_valid;
      wake_task        <= res.wake_task;
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without an execute cycle");

  a_accept_execs: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not enter execute");

  a_single_exec: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("execute lasted more than one cycle");

  a_block_no_wake: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_BLOCK) |-> !wake_valid)
    else $error("blocking result also wakes a task");

endmodule

### design/ipce_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ipce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/ipce_alloc.sv
// Active marks of all endpoints and the lowest-free-endpoint finder.
// Depends on ipce_pkg. Keeps a registered per-group free summary.
module ipce_alloc
  import ipce_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  act_upd_t         upd,
  input  logic [EP_AW-1:0] query_idx,
  output logic             query_act,
  output logic             free_found,
  output logic [EP_AW-1:0] free_idx
);

  logic [NUM_ENDPOINTS-1:0] active;
  logic [NUM_ENDPOINTS-1:0] active_next;
  logic [NUM_GRPS-1:0]      grp_free;
  logic [NUM_GRPS-1:0]      grp_free_next;
  logic [SEL_AW-1:0]        grp_sel;
  logic [GRP_SIZE-1:0]      grp_bits;
  logic [GRP_AW-1:0]        bit_sel;

  always_comb begin
    active_next = active;
    if (upd.set) begin
      active_next[upd.idx] = 1'b1;
    end
    if (upd.clr) begin
      active_next[upd.idx] = 1'b0;
    end
    for (int g = 0; g < NUM_GRPS; g++) begin
      grp_free_next[g] = ~&active_next[g*GRP_SIZE +: GRP_SIZE];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= '0;
      grp_free <= '1;
    end else begin
      active   <= active_next;
      grp_free <= grp_free_next;
    end
  end

  // Pick the lowest group with room, then the lowest free slot in it.
  always_comb begin
    grp_sel = '0;
    for (int g = NUM_GRPS - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        grp_sel = SEL_AW'(g);
      end
    end
    grp_bits = active[grp_sel*GRP_SIZE +: GRP_SIZE];
    bit_sel  = '0;
    for (int i = GRP_SIZE - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        bit_sel = GRP_AW'(i);
      end
    end
  end

  assign free_found = |grp_free;
  assign free_idx   = {grp_sel, bit_sel};
  assign query_act  = active[query_idx];

endmodule

### design/ipce_exec.sv
// Read-modify-write step on one endpoint entry: decides status, wake and writeback.
// Depends on ipce_pkg; purely combinational.
module ipce_exec
  import ipce_pkg::*;
(
  input  op_t                  op,
  input  logic [EP_W-1:0]      ep,
  input  logic [TASK_W-1:0]    caller,
  input  logic [MSG_WIDTH-1:0] msg,
  input  entry_t               entry,
  input  logic                 ep_active,
  input  logic                 free_found,
  input  logic [EP_AW-1:0]     free_idx,
  output exec_out_t            res
);

  logic in_range;
  logic usable;

  assign in_range = ({1'b0, ep} < (EP_W + 1)'(NUM_ENDPOINTS));
  assign usable   = in_range && ep_active;

  always_comb begin
    res            = '0;
    res.status     = ST_DONE;
    res.wr_addr    = ep[EP_AW-1:0];
    res.wr_data    = entry;
    res.act.idx    = ep[EP_AW-1:0];
    case (op)
      OP_CREATE: begin
        if (free_found) begin
          res.created   = EP_W'(free_idx);
          res.act.set   = 1'b1;
          res.act.idx   = free_idx;
          res.wr_en     = 1'b1;
          res.wr_addr   = free_idx;
          res.wr_data   = '0;
        end else begin
          res.status = ST_FAIL;
        end
      end
      OP_DESTROY: begin
        res.act.clr = in_range;
      end
      OP_SEND: begin
        if (!usable) begin
          res.status = ST_FAIL;
        end else begin
          res.wr_en           = 1'b1;
          res.wr_data.payload = msg;
          res.wr_data.pend    = 1'b1;
          if (entry.rcv_wait) begin
            res.wake_valid       = 1'b1;
            res.wake_task        = entry.rcv_id;
            res.wr_data.rcv_wait = 1'b0;
          end else begin
            res.wr_data.snd_wait = 1'b1;
            res.wr_data.snd_id   = caller;
            res.status           = ST_BLOCK;
          end
        end
      end
      OP_RECEIVE: begin
        if (!usable) begin
          res.status = ST_FAIL;
        end else begin
          res.wr_en = 1'b1;
          if (entry.pend) begin
            res.received     = entry.payload;
            res.wr_data.pend = 1'b0;
            if (entry.snd_wait) begin
              res.wake_valid       = 1'b1;
              res.wake_task        = entry.snd_id;
              res.wr_data.snd_wait = 1'b0;
            end
          end else begin
            res.wr_data.rcv_wait = 1'b1;
            res.wr_data.rcv_id   = caller;
            res.status           = ST_BLOCK;
          end
        end
      end
      default: begin
        res.status = ST_FAIL;
      end
    endcase
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ipc_endpoint_rendezvous_table_core.
// Holds its own endpoint table predictor and a scoreboard class; depends on ipce_pkg.
module tb_top;
  import ipce_pkg::*;

  typedef struct {
    status_t               status;
    logic [EP_W-1:0]       created;
    logic [PORT_MSG_W-1:0] received;
    logic                  wake_v;
    logic [TASK_W-1:0]     wake_t;
  } reply_t;

  class endpoint_table_sb;
    bit                    active [NUM_ENDPOINTS];
    bit                    pend [NUM_ENDPOINTS];
    logic [MSG_WIDTH-1:0]  payload [NUM_ENDPOINTS];
    bit                    snd_wait [NUM_ENDPOINTS];
    logic [TASK_W-1:0]     snd_id [NUM_ENDPOINTS];
    bit                    rcv_wait [NUM_ENDPOINTS];
    logic [TASK_W-1:0]     rcv_id [NUM_ENDPOINTS];
    reply_t                replies_due [$];
    int                    errors;

    function new();
      errors = 0;
      for (int i = 0; i < NUM_ENDPOINTS; i++) begin
        active[i] = 0;
        pend[i] = 0;
        payload[i] = '0;
        snd_wait[i] = 0;
        snd_id[i] = '0;
        rcv_wait[i] = 0;
        rcv_id[i] = '0;
      end
    endfunction

    function int free_count();
      int n;
      n = 0;
      for (int i = 0; i < NUM_ENDPOINTS; i++) if (!active[i]) n++;
      return n;
    endfunction

    // Work out the reply to one accepted request and advance the table.
    function void note_request(op_t op, logic [EP_W-1:0] ep, logic [TASK_W-1:0] caller,
                               logic [PORT_MSG_W-1:0] msg);
      reply_t r;
      bit     usable;
      r.status = ST_DONE;
      r.created = '0;
      r.received = '0;
      r.wake_v = 1'b0;
      r.wake_t = '0;
      usable = (ep < NUM_ENDPOINTS) && active[ep];
      if (op == OP_CREATE) begin
        r.status = ST_FAIL;
        for (int i = 0; i < NUM_ENDPOINTS; i++) begin
          if (!active[i]) begin
            active[i] = 1;
            pend[i] = 0;
            snd_wait[i] = 0;
            rcv_wait[i] = 0;
            r.status = ST_DONE;
            r.created = EP_W'(i);
            break;
          end
        end
      end else if (op == OP_DESTROY) begin
        if (ep < NUM_ENDPOINTS) active[ep] = 0;
      end else if (!usable) begin
        r.status = ST_FAIL;
      end else if (op == OP_SEND) begin
        payload[ep] = msg[MSG_WIDTH-1:0];
        pend[ep] = 1;
        if (rcv_wait[ep]) begin
          r.wake_v = 1'b1;
          r.wake_t = rcv_id[ep];
          rcv_wait[ep] = 0;
        end else begin
          snd_wait[ep] = 1;
          snd_id[ep] = caller;
          r.status = ST_BLOCK;
        end
      end else begin
        if (pend[ep]) begin
          r.received[MSG_WIDTH-1:0] = payload[ep];
          pend[ep] = 0;
          if (snd_wait[ep]) begin
            r.wake_v = 1'b1;
            r.wake_t = snd_id[ep];
            snd_wait[ep] = 0;
          end
        end else begin
          rcv_wait[ep] = 1;
          rcv_id[ep] = caller;
          r.status = ST_BLOCK;
        end
      end
      replies_due.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: reply with nothing outstanding: status %0d created %0d", $realtime,
                   got.status, got.created);
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status || got.created !== want.created ||
          got.received !== want.received || got.wake_v !== want.wake_v ||
          got.wake_t !== want.wake_t) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: reply mismatch", $realtime);
          $display("  expected status %0d created %0d msg %h wake %0b/%0d", want.status,
                   want.created, want.received, want.wake_v, want.wake_t);
          $display("  actual   status %0d created %0d msg %h wake %0b/%0d", got.status,
                   got.created, got.received, got.wake_v, got.wake_t);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [1:0]            opcode;
  logic [EP_W-1:0]       endpoint;
  logic [TASK_W-1:0]     caller_task;
  logic [PORT_MSG_W-1:0] message;
  logic                  done;
  logic [1:0]            status;
  logic [EP_W-1:0]       created_endpoint;
  logic [PORT_MSG_W-1:0] received_message;
  logic                  wake_valid;
  logic [TASK_W-1:0]     wake_task;

  endpoint_table_sb sb;
  bit               gaps_on;
  int               n_items;

  ipc_endpoint_rendezvous_table_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .endpoint(endpoint), .caller_task(caller_task), .message(message),
    .done(done), .status(status), .created_endpoint(created_endpoint),
    .received_message(received_message), .wake_valid(wake_valid), .wake_task(wake_task)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Check the reply first: it never belongs to a beat accepted on the same edge.
  always @(posedge clk) begin
    reply_t got;
    if (!rst) begin
      if (done) begin
        got.status = status_t'(status);
        got.created = created_endpoint;
        got.received = received_message;
        got.wake_v = wake_valid;
        got.wake_t = wake_task;
        sb.check_reply(got);
      end
      if (start && !busy) sb.note_request(op_t'(opcode), endpoint, caller_task, message);
    end
  end

  // Present one request and hold it until the block takes the beat.
  task automatic issue(op_t op, logic [EP_W-1:0] ep, logic [TASK_W-1:0] caller,
                       logic [PORT_MSG_W-1:0] msg);
    if (gaps_on && $urandom_range(99) < 13) begin
      start <= 1'b0;
      opcode <= 2'($urandom_range(3));
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    endpoint <= ep;
    caller_task <= caller;
    message <= msg;
    n_items++;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [PORT_MSG_W-1:0] rand_msg();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [5:0] rand_id();
    return 6'($urandom_range(63));
  endfunction

  // Mostly an active endpoint, otherwise anything.
  function automatic logic [EP_W-1:0] pick_ep();
    int base;
    base = $urandom_range(NUM_ENDPOINTS - 1);
    if ($urandom_range(99) < 85)
      for (int i = 0; i < NUM_ENDPOINTS; i++)
        if (sb.active[(base + i) % NUM_ENDPOINTS]) return EP_W'((base + i) % NUM_ENDPOINTS);
    return EP_W'(rand_id());
  endfunction

  task automatic fill_table();
    while (sb.free_count() > 0) issue(OP_CREATE, rand_id(), rand_id(), rand_msg());
    issue(OP_CREATE, rand_id(), rand_id(), rand_msg());
  endtask

  initial begin
    logic [EP_W-1:0] ep;
    int              pick;
    sb = new();
    gaps_on = 1'b1;
    n_items = 0;
    rst <= 1'b1;
    start <= 1'b0;
    opcode <= OP_CREATE;
    endpoint <= '0;
    caller_task <= '0;
    message <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: inactive endpoints, waiter replacement, overwrite, destroy and reuse.
    issue(OP_SEND, 0, 0, '1);
    issue(OP_RECEIVE, 63, 63, '0);
    issue(OP_DESTROY, 5, 7, '0);
    issue(OP_CREATE, 0, 0, '0);
    issue(OP_CREATE, 0, 0, '0);
    issue(OP_RECEIVE, 0, 63, '0);
    issue(OP_RECEIVE, 0, 1, '0);
    issue(OP_SEND, 0, 2, '1);
    issue(OP_SEND, 0, 3, '0);
    issue(OP_SEND, 0, 0, 64'h5555_5555_5555_5555);
    issue(OP_RECEIVE, 0, 4, '0);
    issue(OP_RECEIVE, 0, 5, '0);
    issue(OP_SEND, 1, 63, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(OP_DESTROY, 1, 0, '0);
    issue(OP_RECEIVE, 1, 6, '0);
    issue(OP_DESTROY, 1, 0, '0);
    issue(OP_CREATE, 0, 0, '0);
    issue(OP_RECEIVE, 1, 8, '0);
    issue(OP_DESTROY, 0, 0, '0);
    issue(OP_SEND, 0, 9, '1);
    issue(OP_CREATE, 63, 63, '1);
    issue(OP_RECEIVE, 0, 10, '0);

    // Random: rendezvous sequences on live endpoints, churn, fills and noise.
    while (n_items < 450) begin
      gaps_on = !(n_items >= 180 && n_items < 280);
      pick = $urandom_range(99);
      ep = pick_ep();
      if (pick < 12) begin
        issue(OP_CREATE, rand_id(), rand_id(), rand_msg());
      end else if (pick < 20) begin
        issue(OP_DESTROY, ep, rand_id(), rand_msg());
      end else if (pick < 55) begin
        if ($urandom_range(1)) begin
          issue(OP_SEND, ep, rand_id(), rand_msg());
          issue(OP_RECEIVE, ep, rand_id(), rand_msg());
        end else begin
          issue(OP_RECEIVE, ep, rand_id(), rand_msg());
          issue(OP_SEND, ep, rand_id(), rand_msg());
          issue(OP_RECEIVE, ep, rand_id(), rand_msg());
        end
      end else if (pick < 85) begin
        issue($urandom_range(1) ? OP_SEND : OP_RECEIVE, ep, rand_id(), rand_msg());
      end else if (pick < 89) begin
        fill_table();
      end else begin
        issue(op_t'($urandom_range(3)), rand_id(), rand_id(), rand_msg());
      end
    end
    start <= 1'b0;

    // Drain outstanding replies, then leave the request port quiet before the verdict.
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
